[hdl/ttd_pkg.sv]
// Package for the timed task dispatch table: action and status codes,
// configuration register indices and the default table size. No dependencies.
package ttd_pkg;

  localparam int unsigned MaxTasksDefault = 16;

  typedef enum logic [3:0] {
    ActTick       = 4'd0,
    ActRegister   = 4'd1,
    ActDeregister = 4'd2,
    ActSchedPer   = 4'd3,
    ActSchedOnce  = 4'd4,
    ActResched    = 4'd5,
    ActUnsched    = 4'd6,
    ActPoll       = 4'd7,
    ActStats      = 4'd8
  } action_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatNoFree   = 2'd1,
    StatNotFound = 2'd2
  } status_e;

  localparam logic [1:0] CfgPrescale = 2'd0;
  localparam logic [1:0] CfgActive   = 2'd1;

endpackage

[hdl/timed_task_dispatch_table.sv]
// Timed task dispatch table top level: slot store, millisecond clock and
// the sequencer that scans slots one per cycle. Depends on ttd_pkg.
//
// Each transaction is accepted when idle and answered with one result.
// Tick, read stats and unknown actions go from acceptance through StRead to
// StOut. Register, the lookup actions and poll scan the slot store one entry
// per cycle through a single compare unit, covering at most the active slot
// count (MaxTasks when that count is zero or above MaxTasks). A poll after
// the active count was lowered first subtracts the slot count from the
// cursor in StRead until it is back in range. The input is taken again in
// the cycle after the result is accepted, and a stalled result holds the
// input off. Configuration writes are taken any time.
module timed_task_dispatch_table
  import ttd_pkg::*;
#(
  parameter int unsigned MaxTasks = MaxTasksDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // action[3:0], task_id[19:4], delay_ms[51:20], param_tag[83:52], handler[91:84]
  input  logic [95:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // status[1:0], dispatch_valid[2], due_task_id[18:3], due_handler[26:19],
  // due_param_tag[58:27], idle_minus_busy[90:59], busy_total[122:91],
  // runs_total[154:123]
  output logic [159:0]  m_axis_tdata,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int unsigned IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CntW = $clog2(MaxTasks + 1);

  typedef enum logic [2:0] {
    StIdle, StRead, StScan, StExec, StOut
  } state_e;

  state_e state_q;

  logic [15:0] prescale_q;
  logic [4:0]  active_q;
  logic [15:0] pcount_q;
  logic [31:0] now_q;
  logic [IdxW-1:0] cursor_q;
  logic [31:0] polls_q, disp_q, runs_q;

  logic [15:0] ids_mem  [MaxTasks];
  logic [7:0]  hnd_mem  [MaxTasks];
  logic [31:0] prm_mem  [MaxTasks];
  logic [31:0] dly_mem  [MaxTasks];
  logic [31:0] due_mem  [MaxTasks];
  logic [MaxTasks-1:0] alloc_q, sched_q, per_q;

  logic [3:0]  act_q;
  logic [15:0] id_q;
  logic [31:0] dly_in_q, tag_q;
  logic [7:0]  hin_q;
  logic [IdxW-1:0] idx_q;
  logic [CntW-1:0] steps_q, limit_q;
  logic        found_q;

  logic [15:0] rd_id_q;
  logic [7:0]  rd_hnd_q;
  logic [31:0] rd_prm_q, rd_dly_q, rd_due_q;

  logic [1:0]  o_status_q;
  logic        o_disp_q;
  logic [15:0] o_id_q;
  logic [7:0]  o_hnd_q;
  logic [31:0] o_tag_q, o_imb_q, o_busy_q;

  logic [CntW-1:0] limit_w;
  logic            hit;
  logic [IdxW-1:0] idx_next;
  logic [15:0]     pc_inc;
  logic [31:0]     dsum;

  always_comb begin
    if (active_q == 5'd0 || 32'(active_q) > MaxTasks) limit_w = CntW'(MaxTasks);
    else limit_w = CntW'(active_q);
    case (act_q)
      ActRegister: hit = !alloc_q[idx_q];
      ActPoll:     hit = alloc_q[idx_q];
      default:     hit = alloc_q[idx_q] && (ids_mem[idx_q] == id_q);
    endcase
    if (act_q == ActPoll && 32'(idx_q) + 1 >= 32'(limit_q)) idx_next = '0;
    else idx_next = idx_q + IdxW'(1);
    pc_inc = pcount_q + 16'd1;
    dsum = now_q + ((act_q == ActSchedPer || act_q == ActSchedOnce) ? dly_in_q : rd_dly_q);
  end

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {5'd0, runs_q, o_busy_q, o_imb_q, o_tag_q, o_hnd_q, o_id_q,
                          o_disp_q, o_status_q};

  always_ff @(posedge clk_i) begin
    rd_id_q  <= ids_mem[idx_q];
    rd_hnd_q <= hnd_mem[idx_q];
    rd_prm_q <= prm_mem[idx_q];
    rd_dly_q <= dly_mem[idx_q];
    rd_due_q <= due_mem[idx_q];
    if (state_q == StIdle && s_axis_tvalid) begin
      act_q    <= s_axis_tdata[3:0];
      id_q     <= s_axis_tdata[19:4];
      dly_in_q <= s_axis_tdata[51:20];
      tag_q    <= s_axis_tdata[83:52];
      hin_q    <= s_axis_tdata[91:84];
    end
    if (state_q == StExec && found_q) begin
      case (act_q)
        ActRegister: begin
          ids_mem[idx_q] <= id_q;
          hnd_mem[idx_q] <= hin_q;
          prm_mem[idx_q] <= '0;
          dly_mem[idx_q] <= '0;
          due_mem[idx_q] <= '0;
        end
        ActDeregister: begin
          ids_mem[idx_q] <= '0;
          hnd_mem[idx_q] <= '0;
          prm_mem[idx_q] <= '0;
          dly_mem[idx_q] <= '0;
          due_mem[idx_q] <= '0;
        end
        ActSchedPer, ActSchedOnce: begin
          dly_mem[idx_q] <= dly_in_q;
          due_mem[idx_q] <= dsum;
          prm_mem[idx_q] <= tag_q;
        end
        ActResched: begin
          due_mem[idx_q] <= dsum;
          prm_mem[idx_q] <= tag_q;
        end
        ActUnsched: begin
          due_mem[idx_q] <= '0;
          prm_mem[idx_q] <= '0;
        end
        ActPoll: begin
          if (sched_q[idx_q] && per_q[idx_q] && !(now_q - rd_due_q >= 32'h8000_0000))
            due_mem[idx_q] <= dsum;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      prescale_q <= 16'd1;
      active_q <= 5'd16;
      pcount_q <= '0;
      now_q <= '0;
      cursor_q <= '0;
      polls_q <= '0;
      disp_q <= '0;
      runs_q <= '0;
      alloc_q <= '0;
      sched_q <= '0;
      per_q <= '0;
      idx_q <= '0;
      steps_q <= '0;
      limit_q <= '0;
      found_q <= 1'b0;
      o_status_q <= StatOk;
      o_disp_q <= 1'b0;
      o_id_q <= '0;
      o_hnd_q <= '0;
      o_tag_q <= '0;
      o_imb_q <= '0;
      o_busy_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgPrescale) prescale_q <= cfg_data_i[15:0];
        else if (cfg_index_i == CfgActive) active_q <= cfg_data_i[4:0];
      end
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            state_q <= StRead;
            limit_q <= limit_w;
            steps_q <= '0;
            found_q <= 1'b0;
            if (s_axis_tdata[3:0] == ActPoll) idx_q <= cursor_q;
            else idx_q <= '0;
            o_status_q <= StatOk;
            o_disp_q <= 1'b0;
            o_id_q <= '0;
            o_hnd_q <= '0;
            o_tag_q <= '0;
            o_imb_q <= '0;
            o_busy_q <= '0;
          end
        end
        StRead: begin
          case (act_q)
            ActTick: begin
              if (pc_inc >= prescale_q || pc_inc == 16'd0) begin
                now_q <= now_q + 32'd1;
                pcount_q <= '0;
              end else pcount_q <= pc_inc;
              state_q <= StOut;
            end
            ActStats: begin
              o_imb_q <= polls_q - disp_q;
              o_busy_q <= disp_q;
              polls_q <= '0;
              disp_q <= '0;
              state_q <= StOut;
            end
            ActPoll: begin
              if (32'(idx_q) >= 32'(limit_q)) idx_q <= IdxW'(32'(idx_q) - 32'(limit_q));
              else state_q <= StScan;
            end
            ActRegister, ActDeregister, ActSchedPer, ActSchedOnce, ActResched,
            ActUnsched: state_q <= StScan;
            default: state_q <= StOut;
          endcase
        end
        StScan: begin
          if (steps_q == limit_q) begin
            if (act_q == ActRegister) o_status_q <= StatNoFree;
            else if (act_q != ActPoll) o_status_q <= StatNotFound;
            state_q <= StOut;
          end else if (hit) begin
            found_q <= 1'b1;
            state_q <= StExec;
          end else begin
            idx_q <= idx_next;
            steps_q <= steps_q + CntW'(1);
          end
        end
        StExec: begin
          state_q <= StOut;
          case (act_q)
            ActRegister: alloc_q[idx_q] <= 1'b1;
            ActDeregister: begin
              alloc_q[idx_q] <= 1'b0;
              sched_q[idx_q] <= 1'b0;
              per_q[idx_q] <= 1'b0;
            end
            ActSchedPer, ActSchedOnce: begin
              sched_q[idx_q] <= 1'b1;
              per_q[idx_q] <= (act_q == ActSchedPer);
            end
            ActResched: sched_q[idx_q] <= 1'b1;
            ActUnsched: sched_q[idx_q] <= 1'b0;
            ActPoll: begin
              polls_q <= polls_q + 32'd1;
              cursor_q <= idx_next;
              if (sched_q[idx_q] && !(now_q - rd_due_q >= 32'h8000_0000)) begin
                sched_q[idx_q] <= per_q[idx_q];
                disp_q <= disp_q + 32'd1;
                runs_q <= runs_q + 32'd1;
                o_disp_q <= 1'b1;
                o_id_q <= rd_id_q;
                o_hnd_q <= rd_hnd_q;
                o_tag_q <= rd_prm_q;
              end
            end
            default: ;
          endcase
        end
        StOut: if (m_axis_tready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

[tb/tb.sv]
// Self-checking bench for timed_task_dispatch_table: a directed table, then random
// actions of every kind, each checked against a slot-table predictor.
// Depends on ttd_pkg and the timed_task_dispatch_table RTL.
module tb;
  import ttd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumSlots = MaxTasksDefault;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [31:0] runs_total;
    logic [31:0] busy_total;
    logic [31:0] idle_minus_busy;
    logic [31:0] due_param_tag;
    logic [7:0]  due_handler;
    logic [15:0] due_task_id;
    logic        dispatch_valid;
    logic [1:0]  status;
  } result_t;

  typedef struct {
    logic [3:0]  action;
    logic [15:0] task_id;
    logic [31:0] delay_ms;
    logic [31:0] param_tag;
    logic [7:0]  handler;
    bit          typed;
    logic [1:0]  status;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  timed_task_dispatch_table dut (.*);

  logic [15:0] sl_id[NumSlots];
  logic [7:0]  sl_hnd[NumSlots];
  logic [31:0] sl_tag[NumSlots];
  logic [31:0] sl_dly[NumSlots];
  logic [31:0] sl_due[NumSlots];
  bit          sl_alloc[NumSlots], sl_sched[NumSlots], sl_per[NumSlots];
  logic [31:0] ms_clock, polls, dispatches, runs;
  logic [15:0] prescale, pre_count;
  logic [4:0]  active_cfg;
  int unsigned cursor;

  result_t pending_results[$];
  int unsigned errors, n_sent, n_recv, n_disp, idle_cycles;
  int unsigned snd_idle, rcv_idle;
  bit hold_rx;

  function automatic int unsigned slot_count();
    if (active_cfg == 0 || active_cfg > NumSlots) return NumSlots;
    return active_cfg;
  endfunction

  function automatic result_t dispatch_step(logic [3:0] act, logic [15:0] id,
      logic [31:0] dly, logic [31:0] tag, logic [7:0] hnd);
    result_t r;
    int unsigned n, i;
    int s;
    r = '0;
    n = slot_count();
    s = -1;
    for (int k = 0; k < n; k++)
      if (s < 0 && sl_alloc[k] && sl_id[k] == id) s = k;
    case (act)
      ActTick: begin
        pre_count = pre_count + 16'd1;
        if (pre_count >= prescale || pre_count == 0) begin
          ms_clock = ms_clock + 1;
          pre_count = '0;
        end
      end
      ActRegister: begin
        r.status = StatNoFree;
        for (int k = 0; k < n; k++)
          if (r.status == StatNoFree && !sl_alloc[k]) begin
            sl_id[k] = id;
            sl_hnd[k] = hnd;
            sl_alloc[k] = 1'b1;
            r.status = StatOk;
          end
      end
      ActDeregister, ActSchedPer, ActSchedOnce, ActResched, ActUnsched: begin
        if (s < 0) r.status = StatNotFound;
        else if (act == ActDeregister) begin
          sl_id[s] = '0; sl_hnd[s] = '0; sl_tag[s] = '0; sl_dly[s] = '0;
          sl_due[s] = '0; sl_alloc[s] = 1'b0; sl_sched[s] = 1'b0; sl_per[s] = 1'b0;
        end else if (act == ActSchedPer || act == ActSchedOnce) begin
          sl_dly[s] = dly;
          sl_due[s] = ms_clock + dly;
          sl_tag[s] = tag;
          sl_sched[s] = 1'b1;
          sl_per[s] = (act == ActSchedPer);
        end else if (act == ActResched) begin
          sl_due[s] = ms_clock + sl_dly[s];
          sl_tag[s] = tag;
          sl_sched[s] = 1'b1;
        end else begin
          sl_due[s] = '0; sl_tag[s] = '0; sl_sched[s] = 1'b0;
        end
      end
      ActPoll: begin
        for (int k = 0; k < n; k++) begin
          i = (cursor % n + k) % n;
          if (sl_alloc[i]) begin
            logic [31:0] age;
            polls = polls + 1;
            cursor = (i + 1) % n;
            age = ms_clock - sl_due[i];
            if (sl_sched[i] && !age[31]) begin
              sl_sched[i] = 1'b0;
              dispatches = dispatches + 1;
              r.dispatch_valid = 1'b1;
              r.due_task_id = sl_id[i];
              r.due_handler = sl_hnd[i];
              r.due_param_tag = sl_tag[i];
              if (sl_per[i]) begin
                sl_due[i] = ms_clock + sl_dly[i];
                sl_sched[i] = 1'b1;
              end
              runs = runs + 1;
            end
            break;
          end
        end
      end
      ActStats: begin
        r.idle_minus_busy = polls - dispatches;
        r.busy_total = dispatches;
        polls = '0;
        dispatches = '0;
      end
      default: ;
    endcase
    r.runs_total = runs;
    return r;
  endfunction

  task automatic send_action(logic [3:0] act, logic [15:0] id, logic [31:0] dly,
      logic [31:0] tag, logic [7:0] hnd, bit typed = 1'b0, logic [1:0] st = '0);
    result_t r;
    while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, hnd, tag, dly, id, act};
    do @(posedge clk_i); while (!s_axis_tready);
    r = dispatch_step(act, id, dly, tag, hnd);
    if (typed && r.status != st) begin
      $error("directed status: expected %0d, predicted %0d", st, r.status);
      errors++;
    end
    pending_results.push_back(r);
    n_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgPrescale) prescale = val[15:0];
    else active_cfg = val[4:0];
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || hold_rx) m_axis_tready <= 1'b0;
    else m_axis_tready <= (rcv_idle == 0) || ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_t got, want;
      got = m_axis_tdata[154:0];
      n_recv++;
      if (got.dispatch_valid) n_disp++;
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status); errors++;
        end
        if (got.dispatch_valid !== want.dispatch_valid) begin
          $error("dispatch_valid: expected %0d, got %0d", want.dispatch_valid,
                 got.dispatch_valid); errors++;
        end
        if (got.due_task_id !== want.due_task_id) begin
          $error("due_task_id: expected %h, got %h", want.due_task_id, got.due_task_id);
          errors++;
        end
        if (got.due_handler !== want.due_handler) begin
          $error("due_handler: expected %h, got %h", want.due_handler, got.due_handler);
          errors++;
        end
        if (got.due_param_tag !== want.due_param_tag) begin
          $error("due_param_tag: expected %h, got %h", want.due_param_tag,
                 got.due_param_tag); errors++;
        end
        if (got.idle_minus_busy !== want.idle_minus_busy) begin
          $error("idle_minus_busy: expected %h, got %h", want.idle_minus_busy,
                 got.idle_minus_busy); errors++;
        end
        if (got.busy_total !== want.busy_total) begin
          $error("busy_total: expected %h, got %h", want.busy_total, got.busy_total);
          errors++;
        end
        if (got.runs_total !== want.runs_total) begin
          $error("runs_total: expected %h, got %h", want.runs_total, got.runs_total);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  logic [15:0] id_pool[8] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h0001,
                              16'h8000, 16'h00FF, 16'hA5A5, 16'h7FFF};

  task automatic random_action(int unsigned window);
    int unsigned pick;
    logic [31:0] dly;
    pick = $urandom_range(99);
    dly = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(window);
    if (pick < 30)
      send_action(ActTick, 16'($urandom()), $urandom(), $urandom(), 8'($urandom()));
    else if (pick < 55)
      send_action(ActPoll, 16'($urandom()), $urandom(), $urandom(), 8'($urandom()));
    else if (pick < 65)
      send_action(ActRegister, id_pool[$urandom_range(7)], $urandom(), $urandom(),
                  8'($urandom()));
    else if (pick < 90)
      send_action(4'(3 + $urandom_range(3)), ($urandom_range(19) == 0) ?
                  16'($urandom()) : id_pool[$urandom_range(7)], dly, $urandom(),
                  8'($urandom()));
    else if (pick < 94)
      send_action(ActDeregister, id_pool[$urandom_range(7)], $urandom(), $urandom(),
                  8'($urandom()));
    else if (pick < 97)
      send_action(ActStats, 16'($urandom()), $urandom(), $urandom(), 8'($urandom()));
    else
      send_action(4'(9 + $urandom_range(6)), 16'($urandom()), $urandom(), $urandom(),
                  8'($urandom()));
  endtask

  row_t plan[$];

  initial begin
    row_t e;
    hold_rx = 1'b0;
    snd_idle = 0;
    rcv_idle = 0;
    errors = 0; n_sent = 0; n_recv = 0; n_disp = 0; idle_cycles = 0;
    ms_clock = '0; pre_count = '0; polls = '0; dispatches = '0; runs = '0;
    cursor = 0; prescale = 16'd1; active_cfg = 5'd16;
    for (int k = 0; k < NumSlots; k++) begin
      sl_id[k] = '0; sl_hnd[k] = '0; sl_tag[k] = '0; sl_dly[k] = '0; sl_due[k] = '0;
      sl_alloc[k] = 1'b0; sl_sched[k] = 1'b0; sl_per[k] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan = '{
      '{ActPoll, 16'h0000, 32'h0, 32'h0, 8'h00, 1'b1, StatOk},
      '{ActDeregister, 16'hFFFF, 32'h0, 32'h0, 8'h00, 1'b1, StatNotFound},
      '{ActResched, 16'h0000, 32'h0, 32'h0, 8'h00, 1'b1, StatNotFound},
      '{ActRegister, 16'hFFFF, 32'h0, 32'h0, 8'hFF, 1'b1, StatOk},
      '{ActRegister, 16'h0000, 32'h0, 32'h0, 8'h00, 1'b1, StatOk},
      '{ActRegister, 16'hFFFF, 32'h0, 32'h0, 8'h5A, 1'b1, StatOk},
      '{ActSchedPer, 16'hFFFF, 32'h0, 32'hFFFFFFFF, 8'h00, 1'b1, StatOk},
      '{ActSchedOnce, 16'h0000, 32'hFFFFFFFF, 32'h0, 8'h00, 1'b1, StatOk},
      '{ActPoll, 16'h0, 32'h0, 32'h0, 8'h0, 1'b0, StatOk},
      '{ActPoll, 16'h0, 32'h0, 32'h0, 8'h0, 1'b0, StatOk},
      '{ActPoll, 16'h0, 32'h0, 32'h0, 8'h0, 1'b0, StatOk},
      '{ActTick, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 1'b1, StatOk},
      '{ActSchedOnce, 16'h0000, 32'h7FFFFFFF, 32'h1234, 8'h00, 1'b1, StatOk},
      '{ActResched, 16'hFFFF, 32'h0, 32'hA5A5A5A5, 8'h00, 1'b1, StatOk},
      '{ActPoll, 16'h0, 32'h0, 32'h0, 8'h0, 1'b0, StatOk},
      '{ActUnsched, 16'hFFFF, 32'h0, 32'h0, 8'h00, 1'b1, StatOk},
      '{ActPoll, 16'h0, 32'h0, 32'h0, 8'h0, 1'b0, StatOk},
      '{ActStats, 16'h0, 32'h0, 32'h0, 8'h0, 1'b0, StatOk},
      '{4'd15, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 1'b1, StatOk},
      '{ActDeregister, 16'h0000, 32'h0, 32'h0, 8'h00, 1'b1, StatOk},
      '{ActStats, 16'h0, 32'h0, 32'h0, 8'h0, 1'b0, StatOk}
    };
    foreach (plan[p]) begin
      e = plan[p];
      send_action(e.action, e.task_id, e.delay_ms, e.param_tag, e.handler, e.typed,
                  e.status);
    end

    // full table, then shrink active count to one
    for (int k = 0; k < NumSlots + 1; k++)
      send_action(ActRegister, k[15:0], '0, '0, k[7:0], 1'b1,
                  (k < NumSlots - 2) ? StatOk : StatNoFree);
    write_reg(CfgActive, 32'd1);
    write_reg(CfgPrescale, 32'd0);
    snd_idle = 19; rcv_idle = 73;
    for (int k = 0; k < 150; k++) random_action(4);

    write_reg(CfgActive, 32'd4);
    write_reg(CfgPrescale, 32'hFFFF);
    for (int k = 0; k < 40; k++) random_action(2);

    write_reg(CfgActive, 32'd0);
    write_reg(CfgPrescale, 32'd3);
    snd_idle = 73; rcv_idle = 19;
    for (int k = 0; k < 250; k++) random_action(6);

    // hold the result side while offering items so input backs up
    write_reg(CfgActive, 32'd31);
    write_reg(CfgPrescale, 32'd1);
    snd_idle = 0; rcv_idle = 0;
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      for (int k = 0; k < 20; k++) random_action(3);
    join
    write_reg(CfgActive, 32'd7);
    for (int k = 0; k < 290; k++) random_action(3);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("Sent %0d actions, checked %0d results, %0d dispatches seen.",
             n_sent, n_recv, n_disp);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
